@@ rtl/core/ute_pkg.sv @@
// Shared types, constants and rounding helper for the UV sphere triangle emitter.
`timescale 1ns / 1ps

package ute_pkg;

  localparam int unsigned MAX_RINGS   = 1024;
  localparam int unsigned MAX_SECTORS = 1024;
  localparam int unsigned MIN_RINGS   = 2;
  localparam int unsigned MIN_SECTORS = 3;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned RAD_W = 31;
  localparam int unsigned ANG_W = 32;

  localparam int unsigned DIV_STEPS   = 4;
  localparam int unsigned DIV_STAGES  = ANG_W / DIV_STEPS;
  localparam int unsigned TRIG_STAGES = 8;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;
  localparam logic signed [65:0] ONE_Q30_W = 66'sd1073741824;
  localparam logic [ANG_W-1:0]   QUARTER   = 32'h4000_0000;
  localparam logic signed [15:0] NORM_ONE  = 16'sd16384;

  localparam logic signed [32:0] K11 = 33'sd3864;
  localparam logic signed [32:0] HORNER_K [5] = '{
    33'sd172272, -33'sd5026995, 33'sd85569306, -33'sd693598668, 33'sd1686629713
  };

  localparam logic [RAD_W-1:0] RESET_RADIUS  = 31'd65536;
  localparam logic [CNT_W-1:0] RESET_RINGS   = 11'd2;
  localparam logic [CNT_W-1:0] RESET_SECTORS = 11'd3;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_RINGS   = 2'd1,
    REG_SECTORS = 2'd2
  } reg_index_e;

  typedef enum logic [1:0] {
    QK_FIRST,
    QK_LAST,
    QK_MID
  } quad_kind_e;

  typedef struct packed {
    logic [IDX_W-1:0] ring_index;
    logic [IDX_W-1:0] sector_index;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               last_corner;
  } out_word_t;

  typedef struct packed {
    logic last;
    logic pole_top;
    logic pole_bot;
  } corner_tag_t;

  typedef struct packed {
    logic [CNT_W-1:0] r;
    logic [CNT_W-1:0] s;
    corner_tag_t      tag;
  } corner_t;

  // Arithmetic shift right by n, rounding to nearest with ties away from zero.
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] p,
                                                   input int unsigned n);
    logic signed [65:0] h;
    h = 66'sd1 <<< (n - 1);
    return (p + h - $signed({65'd0, p[65]})) >>> n;
  endfunction

endpackage

@@ rtl/core/ute_seq.sv @@
// Quad sequencer: holds one quad and issues its triangle corners one per cycle while enabled.
`timescale 1ns / 1ps

module ute_seq import ute_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [RAD_W-1:0] radius_i,
  input  logic [CNT_W-1:0] rings_i,
  input  logic [CNT_W-1:0] sectors_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_word_t         in_word_i,
  output logic             corner_valid_o,
  output corner_t          corner_o
);

  logic             busy_q, busy_d;
  logic [2:0]       k_q, k_d;
  quad_kind_e       mode_q, mode_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic             accept, quad_ok, last_k;
  logic [2:0]       last_idx;
  logic             dr, ds;
  logic [CNT_W-1:0] s_raw;

  assign last_idx   = (mode_q == QK_MID) ? 3'd5 : 3'd2;
  assign last_k     = (k_q == last_idx);
  assign in_ready_o = !busy_q || (en_i && last_k);
  assign accept     = in_valid_i && in_ready_o;
  assign quad_ok    = (radius_i != '0) && ({1'b0, in_word_i.ring_index} < rings_i) &&
                      ({1'b0, in_word_i.sector_index} < sectors_i);

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    mode_d = mode_q;
    i_d    = i_q;
    j_d    = j_q;
    if (busy_q && en_i) begin
      if (last_k) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + 3'd1;
      end
    end
    if (accept) begin
      busy_d = quad_ok;
      k_d    = '0;
      i_d    = in_word_i.ring_index;
      j_d    = in_word_i.sector_index;
      priority if (in_word_i.ring_index == '0) begin
        mode_d = QK_FIRST;
      end else if ({1'b0, in_word_i.ring_index} == rings_i - 11'd1) begin
        mode_d = QK_LAST;
      end else begin
        mode_d = QK_MID;
      end
    end
  end

  // Corner offsets: TL, BL, BR, TL, BR, TR; the last ring ends on TR instead of BR.
  always_comb begin
    unique case (k_q)
      3'd1, 3'd4: dr = 1'b1;
      3'd2:       dr = (mode_q != QK_LAST);
      default:    dr = 1'b0;
    endcase
    ds = (k_q == 3'd2) || (k_q == 3'd4) || (k_q == 3'd5);
  end

  assign s_raw = {1'b0, j_q} + {10'd0, ds};

  always_comb begin
    corner_o.r            = {1'b0, i_q} + {10'd0, dr};
    corner_o.s            = (s_raw == sectors_i) ? '0 : s_raw;
    corner_o.tag.last     = last_k;
    corner_o.tag.pole_top = (corner_o.r == '0);
    corner_o.tag.pole_bot = (corner_o.r == rings_i);
  end

  assign corner_valid_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      mode_q <= QK_FIRST;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !en_i |=> busy_q && $stable(k_q))
    else $error("corner sequence moved during a stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (k_q <= 3'd5) && ((mode_q == QK_MID) || (k_q <= 3'd2)))
    else $error("corner counter beyond the quad's corners");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && busy_q |-> last_k && en_i)
    else $error("new quad taken before the current one was issued");

endmodule

@@ rtl/core/ute_angle.sv @@
// Angle pipeline: polar and azimuth turn fractions by restoring division.
`timescale 1ns / 1ps

module ute_angle import ute_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [CNT_W-1:0] rings_i,
  input  logic [CNT_W-1:0] sectors_i,
  input  logic             corner_valid_i,
  input  corner_t          corner_i,
  output logic             angle_valid_o,
  output logic [ANG_W-1:0] phi_o,
  output logic [ANG_W-1:0] theta_o,
  output corner_tag_t      tag_o
);

  typedef struct packed {
    logic [IDX_W-1:0] rem_p;
    logic [IDX_W-1:0] rem_t;
    logic [ANG_W-1:0] q_p;
    logic [ANG_W-1:0] q_t;
    logic             q_top;
    corner_tag_t      tag;
  } div_st_t;

  div_st_t               st_q [DIV_STAGES];
  div_st_t               st_d [DIV_STAGES];
  div_st_t               init;
  logic [DIV_STAGES-1:0] vld_q;

  function automatic div_st_t div_steps(input div_st_t a, input logic [CNT_W-1:0] den_p,
                                        input logic [CNT_W-1:0] den_t);
    div_st_t          b;
    logic [CNT_W-1:0] tp;
    logic [CNT_W-1:0] tt;
    b = a;
    for (int n = 0; n < DIV_STEPS; n++) begin
      tp = {b.rem_p, 1'b0};
      tt = {b.rem_t, 1'b0};
      if (tp >= den_p) begin
        tp = tp - den_p;
        b.q_p = {b.q_p[ANG_W-2:0], 1'b1};
      end else begin
        b.q_p = {b.q_p[ANG_W-2:0], 1'b0};
      end
      if (tt >= den_t) begin
        tt = tt - den_t;
        b.q_t = {b.q_t[ANG_W-2:0], 1'b1};
      end else begin
        b.q_t = {b.q_t[ANG_W-2:0], 1'b0};
      end
      b.rem_p = tp[IDX_W-1:0];
      b.rem_t = tt[IDX_W-1:0];
    end
    return b;
  endfunction

  // The ring at the bottom pole divides evenly and sets the quotient's top bit.
  always_comb begin
    init.q_top = (corner_i.r == rings_i);
    init.rem_p = init.q_top ? '0 : corner_i.r[IDX_W-1:0];
    init.rem_t = corner_i.s[IDX_W-1:0];
    init.q_p   = '0;
    init.q_t   = '0;
    init.tag   = corner_i.tag;
  end

  always_comb begin
    st_d[0] = div_steps(init, rings_i, sectors_i);
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_d[k] = div_steps(st_q[k-1], rings_i, sectors_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STAGES-2:0], corner_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign angle_valid_o = vld_q[DIV_STAGES-1];
  assign phi_o         = {st_q[DIV_STAGES-1].q_top, st_q[DIV_STAGES-1].q_p[ANG_W-1:1]};
  assign theta_o       = st_q[DIV_STAGES-1].q_t;
  assign tag_o         = st_q[DIV_STAGES-1].tag;

endmodule

@@ rtl/core/ute_trig.sv @@
// Sine pipeline: four quarter-wave polynomial lanes for sin/cos of both angles.
`timescale 1ns / 1ps

module ute_trig import ute_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               angle_valid_i,
  input  logic [ANG_W-1:0]   phi_i,
  input  logic [ANG_W-1:0]   theta_i,
  input  corner_tag_t        tag_i,
  output logic               trig_valid_o,
  output logic signed [31:0] sin_phi_o,
  output logic signed [31:0] cos_phi_o,
  output logic signed [31:0] sin_theta_o,
  output logic signed [31:0] cos_theta_o,
  output corner_tag_t        tag_o
);

  localparam int unsigned NUM_LANES = 4;

  typedef struct packed {
    logic [30:0]        v;
    logic [30:0]        s;
    logic signed [32:0] p;
    logic               neg;
    logic               full;
  } lane_t;

  lane_t                  st_q [TRIG_STAGES][NUM_LANES];
  lane_t                  st_d [TRIG_STAGES][NUM_LANES];
  corner_tag_t            tag_q [TRIG_STAGES];
  logic [TRIG_STAGES-1:0] vld_q;
  logic [ANG_W-1:0]       ang [NUM_LANES];

  function automatic lane_t lane_prep(input logic [ANG_W-1:0] a);
    lane_t b;
    b      = '0;
    b.v    = a[30] ? (ONE_Q30 - {1'b0, a[29:0]}) : {1'b0, a[29:0]};
    b.neg  = a[31];
    b.full = (b.v == ONE_Q30);
    return b;
  endfunction

  // Stage 1 squares v, stages 2..6 run Horner, the last stage scales by v and signs.
  function automatic lane_t lane_step(input int unsigned k, input lane_t a);
    lane_t              b;
    logic signed [63:0] vv;
    logic signed [64:0] pm;
    logic signed [65:0] r;
    logic [2:0]         hk;
    b  = a;
    vv = '0;
    pm = '0;
    r  = '0;
    hk = 3'(k - 2);
    if (k == 1) begin
      vv  = $signed({1'b0, a.v}) * $signed({1'b0, a.v});
      r   = rnd_shift(66'(vv), 30);
      b.s = r[30:0];
      b.p = -K11;
    end else if (k == TRIG_STAGES - 1) begin
      pm = a.p * $signed({1'b0, a.v});
      r  = rnd_shift(66'(pm), 30);
      if (r < 0) begin
        r = '0;
      end else if (r > ONE_Q30_W) begin
        r = ONE_Q30_W;
      end
      if (a.full) begin
        r = ONE_Q30_W;
      end
      if (a.neg) begin
        r = -r;
      end
      b.p = r[32:0];
    end else begin
      pm  = a.p * $signed({1'b0, a.s});
      r   = rnd_shift(66'(pm), 30) + 66'(HORNER_K[hk]);
      b.p = r[32:0];
    end
    return b;
  endfunction

  assign ang[0] = phi_i;
  assign ang[1] = phi_i + QUARTER;
  assign ang[2] = theta_i;
  assign ang[3] = theta_i + QUARTER;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      st_d[0][l] = lane_prep(ang[l]);
      for (int k = 1; k < TRIG_STAGES; k++) begin
        st_d[k][l] = lane_step(k, st_q[k-1][l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[TRIG_STAGES-2:0], angle_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int k = 1; k < TRIG_STAGES; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      for (int k = 0; k < TRIG_STAGES; k++) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          st_q[k][l] <= st_d[k][l];
        end
      end
    end
  end

  assign trig_valid_o = vld_q[TRIG_STAGES-1];
  assign sin_phi_o    = st_q[TRIG_STAGES-1][0].p[31:0];
  assign cos_phi_o    = st_q[TRIG_STAGES-1][1].p[31:0];
  assign sin_theta_o  = st_q[TRIG_STAGES-1][2].p[31:0];
  assign cos_theta_o  = st_q[TRIG_STAGES-1][3].p[31:0];
  assign tag_o        = tag_q[TRIG_STAGES-1];

endmodule

@@ rtl/core/ute_geom.sv @@
// Geometry stages: ring radius, positions and normals, ending in the output register.
`timescale 1ns / 1ps

module ute_geom import ute_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [RAD_W-1:0]   radius_i,
  input  logic               trig_valid_i,
  input  logic signed [31:0] sin_phi_i,
  input  logic signed [31:0] cos_phi_i,
  input  logic signed [31:0] sin_theta_i,
  input  logic signed [31:0] cos_theta_i,
  input  corner_tag_t        tag_i,
  output logic               out_valid_o,
  output out_word_t          out_word_o
);

  typedef struct packed {
    logic signed [31:0] ringrad;
    logic signed [31:0] py;
    logic signed [31:0] st;
    logic signed [31:0] ct;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    corner_tag_t        tag;
  } g1_t;

  g1_t                g1_q, g1_d;
  out_word_t          out_q, out_d;
  logic               v1_q, v2_q;
  logic signed [31:0] rad_s;
  logic signed [63:0] m_rr, m_py, m_nx, m_nz, m_px, m_pz;
  logic signed [65:0] r_rr, r_py, r_nx, r_nz, r_ny, r_px, r_pz;

  assign rad_s = $signed({1'b0, radius_i});

  always_comb begin
    m_rr = rad_s * sin_phi_i;
    m_py = rad_s * cos_phi_i;
    m_nx = sin_phi_i * cos_theta_i;
    m_nz = sin_phi_i * sin_theta_i;
    r_rr = rnd_shift(66'(m_rr), 30);
    r_py = rnd_shift(66'(m_py), 30);
    r_nx = rnd_shift(66'(m_nx), 46);
    r_nz = rnd_shift(66'(m_nz), 46);
    r_ny = rnd_shift(66'(cos_phi_i), 16);
    g1_d.ringrad = r_rr[31:0];
    g1_d.py      = r_py[31:0];
    g1_d.st      = sin_theta_i;
    g1_d.ct      = cos_theta_i;
    g1_d.nx      = r_nx[15:0];
    g1_d.ny      = r_ny[15:0];
    g1_d.nz      = r_nz[15:0];
    g1_d.tag     = tag_i;
  end

  always_comb begin
    m_px = g1_q.ringrad * g1_q.ct;
    m_pz = g1_q.ringrad * g1_q.st;
    r_px = rnd_shift(66'(m_px), 30);
    r_pz = rnd_shift(66'(m_pz), 30);
    out_d.pos_x       = r_px[31:0];
    out_d.pos_y       = g1_q.py;
    out_d.pos_z       = r_pz[31:0];
    out_d.last_corner = g1_q.tag.last;
    // Pole corners get exact axis normals; their positions stay as computed.
    priority if (g1_q.tag.pole_top) begin
      out_d.norm_x = '0;
      out_d.norm_y = NORM_ONE;
      out_d.norm_z = '0;
    end else if (g1_q.tag.pole_bot) begin
      out_d.norm_x = '0;
      out_d.norm_y = -NORM_ONE;
      out_d.norm_z = '0;
    end else begin
      out_d.norm_x = g1_q.nx;
      out_d.norm_y = g1_q.ny;
      out_d.norm_z = g1_q.nz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= trig_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q  <= g1_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/core/uv_sphere_triangle_emitter_core.sv @@
// Top level of the UV sphere triangle emitter: registers, sequencer and corner pipeline.
// Each corner word passes through the sequencer, then the angle, sine and geometry stages; later corners follow.
// Throughput: one corner word per cycle while the output is not stalled; a quad gives 3 or 6 corner words, or none.
// The rate is set by the sequencer, which issues one corner per cycle into the pipeline while it advances.
// Reset is asynchronous and active low; it empties the pipeline and restores the registers.
`timescale 1ns / 1ps

module uv_sphere_triangle_emitter_core import ute_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers. Writes land in the access phase; pready never stalls.
  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] rings_q, sectors_q;
  logic [CNT_W-1:0] rings_eff, sectors_eff;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RESET_RADIUS;
      rings_q   <= RESET_RINGS;
      sectors_q <= RESET_SECTORS;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_RADIUS:  radius_q  <= pwdata[RAD_W-1:0];
        REG_RINGS:   rings_q   <= pwdata[CNT_W-1:0];
        REG_SECTORS: sectors_q <= pwdata[CNT_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS:  prdata = {1'b0, radius_q};
      REG_RINGS:   prdata = {21'd0, rings_q};
      REG_SECTORS: prdata = {21'd0, sectors_q};
      default:     prdata = '0;
    endcase
  end

  // The counts are clamped into the range the angle dividers and sequencer support.
  always_comb begin
    priority if (rings_q > CNT_W'(MAX_RINGS)) begin
      rings_eff = CNT_W'(MAX_RINGS);
    end else if (rings_q < CNT_W'(MIN_RINGS)) begin
      rings_eff = CNT_W'(MIN_RINGS);
    end else begin
      rings_eff = rings_q;
    end
    priority if (sectors_q > CNT_W'(MAX_SECTORS)) begin
      sectors_eff = CNT_W'(MAX_SECTORS);
    end else if (sectors_q < CNT_W'(MIN_SECTORS)) begin
      sectors_eff = CNT_W'(MIN_SECTORS);
    end else begin
      sectors_eff = sectors_q;
    end
  end

  // Every stage advances together. The last stage is the output register, so the
  // pipeline moves whenever that register is empty or its word is being taken.
  logic en;
  assign en = !out_valid_o || out_ready_i;

  logic               corner_valid, angle_valid, trig_valid;
  corner_t            corner;
  logic [ANG_W-1:0]   phi, theta;
  corner_tag_t        angle_tag, trig_tag;
  logic signed [31:0] sin_phi, cos_phi, sin_theta, cos_theta;

  // The sequencer checks the quad, drops it if it gives no corners, and otherwise
  // issues its corners one per cycle while the pipeline advances, wrapping the seam and marking pole corners.
  ute_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .radius_i       (radius_q),
    .rings_i        (rings_eff),
    .sectors_i      (sectors_eff),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_word_i      (in_word_i),
    .corner_valid_o (corner_valid),
    .corner_o       (corner)
  );

  // Eight stages of four restoring-division steps turn the indices into turn fractions.
  ute_angle u_angle (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .rings_i        (rings_eff),
    .sectors_i      (sectors_eff),
    .corner_valid_i (corner_valid),
    .corner_i       (corner),
    .angle_valid_o  (angle_valid),
    .phi_o          (phi),
    .theta_o        (theta),
    .tag_o          (angle_tag)
  );

  // Eight stages evaluate the quarter-wave polynomial: the first folds the angle, each later one does one multiply.
  ute_trig u_trig (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .angle_valid_i (angle_valid),
    .phi_i         (phi),
    .theta_i       (theta),
    .tag_i         (angle_tag),
    .trig_valid_o  (trig_valid),
    .sin_phi_o     (sin_phi),
    .cos_phi_o     (cos_phi),
    .sin_theta_o   (sin_theta),
    .cos_theta_o   (cos_theta),
    .tag_o         (trig_tag)
  );

  // Two stages scale by the radius and form the normals; the second is the output word.
  ute_geom u_geom (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .radius_i     (radius_q),
    .trig_valid_i (trig_valid),
    .sin_phi_i    (sin_phi),
    .cos_phi_i    (cos_phi),
    .sin_theta_i  (sin_theta),
    .cos_theta_i  (cos_theta),
    .tag_i        (trig_tag),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o)
  );

endmodule

@@ tb/uv_sphere_triangle_emitter_core_tb.sv @@
// Testbench for the UV sphere triangle emitter core: self-checking, with random handshakes.
`timescale 1ns / 1ps

module uv_sphere_triangle_emitter_core_tb;
  import ute_pkg::*;

  // Register index with no register behind it; writes there must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Cycles to let pass after the last expected corner word, so the pipeline is empty.
  localparam int unsigned DRAIN_CYCLES = 30;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_word;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  uv_sphere_triangle_emitter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Our own copy of the register file, updated when a write lands.
  logic [RAD_W-1:0] radius_reg;
  logic [CNT_W-1:0] rings_reg;
  logic [CNT_W-1:0] sectors_reg;

  // Corner words still to come out of the block, oldest first.
  out_word_t pending_corners[$];
  int unsigned error_count;

  // Percent chance per cycle that the sender holds off or the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point geometry, mirroring the block's arithmetic.
  // ---------------------------------------------------------------------------

  // Divide by 2^n, rounding to nearest with ties away from zero.
  function automatic longint round_shift(longint p, int unsigned n);
    longint mag;
    mag = (p < 0) ? -p : p;
    mag = (mag + (longint'(1) <<< (n - 1))) >>> n;
    return (p < 0) ? -mag : mag;
  endfunction

  // Quarter-wave sine in Q30 for v in [0, 2^30], by an odd Horner polynomial.
  function automatic longint quarter_wave(longint v);
    longint sq, acc, res;
    if (v >= 64'sd1073741824) return 64'sd1073741824;
    sq  = round_shift(v * v, 30);
    acc = -64'sd3864;
    acc = 64'sd172272     + round_shift(acc * sq, 30);
    acc = -64'sd5026995   + round_shift(acc * sq, 30);
    acc = 64'sd85569306   + round_shift(acc * sq, 30);
    acc = -64'sd693598668 + round_shift(acc * sq, 30);
    acc = 64'sd1686629713 + round_shift(acc * sq, 30);
    res = round_shift(acc * v, 30);
    if (res < 0) res = 0;
    if (res > 64'sd1073741824) res = 64'sd1073741824;
    return res;
  endfunction

  // Sine of an angle given as a 32-bit fraction of a full turn, in Q30.
  function automatic longint turn_sine(logic [31:0] a);
    longint u;
    u = longint'(a[29:0]);
    case (a[31:30])
      2'd0:    return quarter_wave(u);
      2'd1:    return quarter_wave(64'sd1073741824 - u);
      2'd2:    return -quarter_wave(u);
      default: return -quarter_wave(64'sd1073741824 - u);
    endcase
  endfunction

  function automatic int unsigned clamp_count(logic [CNT_W-1:0] raw, int unsigned lo,
                                              int unsigned hi);
    int unsigned v;
    v = raw;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // Position and normal of grid corner (r, s) on the current sphere.
  function automatic out_word_t corner_at(int unsigned r, int unsigned s, int unsigned nr,
                                          int unsigned ns, logic is_last);
    out_word_t w;
    logic [31:0] phi, theta;
    longint sp, cp, st, ct, rad, ring_rad, nx, ny, nz;
    longint unsigned wide;
    wide  = (longint'(r) << 31) / nr;
    phi   = wide[31:0];
    wide  = (longint'(s) << 32) / ns;
    theta = wide[31:0];
    sp = turn_sine(phi);
    cp = turn_sine(phi + QUARTER);
    st = turn_sine(theta);
    ct = turn_sine(theta + QUARTER);
    rad = longint'(radius_reg);
    ring_rad = round_shift(rad * sp, 30);
    if (r == 0) begin
      nx = 0; ny = 16384; nz = 0;
    end else if (r == nr) begin
      nx = 0; ny = -16384; nz = 0;
    end else begin
      nx = round_shift(sp * ct, 46);
      ny = round_shift(cp, 16);
      nz = round_shift(sp * st, 46);
    end
    w.pos_x       = 32'(round_shift(ring_rad * ct, 30));
    w.pos_y       = 32'(round_shift(rad * cp, 30));
    w.pos_z       = 32'(round_shift(ring_rad * st, 30));
    w.norm_x      = 16'(nx);
    w.norm_y      = 16'(ny);
    w.norm_z      = 16'(nz);
    w.last_corner = is_last;
    return w;
  endfunction

  // Queue up the triangle corners that one quad should produce.
  function automatic void expect_quad_corners(in_word_t q);
    int unsigned nr, ns, i, j, n;
    int unsigned cr[6], cs[6];
    nr = clamp_count(rings_reg, MIN_RINGS, MAX_RINGS);
    ns = clamp_count(sectors_reg, MIN_SECTORS, MAX_SECTORS);
    i  = q.ring_index;
    j  = q.sector_index;
    if (radius_reg == 0 || i >= nr || j >= ns) return;
    cr[0] = i;     cs[0] = j;
    cr[1] = i + 1; cs[1] = j;
    cr[2] = i + 1; cs[2] = j + 1;
    n = 3;
    if (i != 0 && i == nr - 1) begin
      // The bottom ring closes with the top-right corner instead.
      cr[2] = i;   cs[2] = j + 1;
    end else if (i != 0) begin
      cr[3] = i;     cs[3] = j;
      cr[4] = i + 1; cs[4] = j + 1;
      cr[5] = i;     cs[5] = j + 1;
      n = 6;
    end
    for (int k = 0; k < n; k++)
      pending_corners = {pending_corners, corner_at(cr[k], cs[k], nr, ns, k == n - 1)};
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and a field-by-field check of each word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_corners.size() == 0) begin
        $error("unexpected corner word %h", out_word);
        error_count++;
      end else begin
        exp_w = pending_corners.pop_front();
        if (out_word.pos_x !== exp_w.pos_x) begin
          $error("pos_x expected %0d got %0d", exp_w.pos_x, out_word.pos_x);
          error_count++;
        end
        if (out_word.pos_y !== exp_w.pos_y) begin
          $error("pos_y expected %0d got %0d", exp_w.pos_y, out_word.pos_y);
          error_count++;
        end
        if (out_word.pos_z !== exp_w.pos_z) begin
          $error("pos_z expected %0d got %0d", exp_w.pos_z, out_word.pos_z);
          error_count++;
        end
        if (out_word.norm_x !== exp_w.norm_x) begin
          $error("norm_x expected %0d got %0d", exp_w.norm_x, out_word.norm_x);
          error_count++;
        end
        if (out_word.norm_y !== exp_w.norm_y) begin
          $error("norm_y expected %0d got %0d", exp_w.norm_y, out_word.norm_y);
          error_count++;
        end
        if (out_word.norm_z !== exp_w.norm_z) begin
          $error("norm_z expected %0d got %0d", exp_w.norm_z, out_word.norm_z);
          error_count++;
        end
        if (out_word.last_corner !== exp_w.last_corner) begin
          $error("last_corner expected %0b got %0b", exp_w.last_corner,
                 out_word.last_corner);
          error_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offer one quad word, with random hold-off before it, and predict on acceptance.
  task automatic send_quad(input int unsigned ring, input int unsigned sector);
    in_word_t w;
    w.ring_index   = ring[IDX_W-1:0];
    w.sector_index = sector[IDX_W-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    expect_quad_corners(w);
  endtask

  // Stop sending and wait until every expected corner has come, then let the pipe empty.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Two-phase register write; our copy changes at the access edge.
  // The bus then idles before the next transfer.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_RADIUS:  radius_reg  = data[RAD_W-1:0];
      REG_RINGS:   rings_reg   = data[CNT_W-1:0];
      REG_SECTORS: sectors_reg = data[CNT_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sphere(input logic [31:0] rad, input logic [31:0] nr,
                            input logic [31:0] ns);
    drain();
    write_reg(REG_RADIUS, rad);
    write_reg(REG_RINGS, nr);
    write_reg(REG_SECTORS, ns);
  endtask

  // Index biased toward the edges of [0, limit), with some out-of-range noise.
  function automatic int unsigned pick_index(int unsigned limit);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom_range(1023);
    if (roll < 20) return 0;
    if (roll < 30) return limit - 1;
    return $urandom_range(limit - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset values, pole and seam corners, every quad shape, clamping and zero radius.
  task automatic test_directed;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Reset geometry: two rings, so only first and last ring quads exist.
    send_quad(0, 0);
    send_quad(1, 2);
    send_quad(2, 0);
    send_quad(0, 3);
    send_quad(1023, 1023);
    // Eight by eight sphere: middle rings and the wrap-around sector.
    set_sphere(32'h0003_0000, 8, 8);
    send_quad(3, 7);
    send_quad(7, 0);
    send_quad(0, 7);
    // Writes to a missing register must not disturb anything.
    drain();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_quad(4, 4);
    // Largest radius with the largest counts clamped down.
    set_sphere(32'hFFFF_FFFF, 2047, 2047);
    send_quad(1023, 1023);
    send_quad(0, 1023);
    send_quad(512, 256);
    send_quad(682, 341);
    // Counts of zero and one clamp up to the minimum shape.
    set_sphere(32'h0000_0001, 0, 1);
    send_quad(0, 2);
    send_quad(1, 0);
    send_quad(2, 2);
    // Zero radius suppresses everything.
    set_sphere(32'h0, 5, 5);
    send_quad(1, 1);
    send_quad(0, 0);
  endtask

  // One random phase with a random sphere and the given idling behavior.
  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned count);
    int unsigned nr, ns;
    logic [31:0] rad;
    case ($urandom_range(3))
      0:       rad = $urandom_range(32'h0040_0000);
      1:       rad = 32'h7FFF_FFFF;
      default: rad = $urandom;
    endcase
    nr = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(2, 40);
    ns = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(3, 40);
    set_sphere(rad, nr, ns);
    if (radius_reg == 0) write_reg(REG_RADIUS, 32'h0001_0000);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    nr = clamp_count(rings_reg, MIN_RINGS, MAX_RINGS);
    ns = clamp_count(sectors_reg, MIN_SECTORS, MAX_SECTORS);
    for (int k = 0; k < count; k++) begin
      send_quad(pick_index(nr), pick_index(ns));
      // Once per phase, let everything come out before going on.
      if (k == count / 2) drain();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_word        = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    radius_reg     = RESET_RADIUS;
    rings_reg      = RESET_RINGS;
    sectors_reg    = RESET_SECTORS;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(0, 0, 14);
    test_random_phase(0, 0, 14);
    test_random_phase(87, 0, 14);
    test_random_phase(87, 0, 14);
    test_random_phase(0, 87, 14);
    test_random_phase(0, 87, 14);
    test_random_phase(19, 19, 14);
    test_random_phase(19, 19, 14);
    send_idle_pct = 0;
    drain();

    if (error_count == 0) begin
      $display("uv_sphere_triangle_emitter_core_tb: clean");
    end else begin
      $display("uv_sphere_triangle_emitter_core_tb: errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #8ms;
    $display("uv_sphere_triangle_emitter_core_tb: errors");
    $finish;
  end

endmodule
